### rtl/core/vrd_pkg.sv
// vrd_pkg: request/result payload types, widths and constants for the
// velocity reversal detector. No dependencies.
package vrd_pkg;

  localparam int POS_W     = 32;
  localparam int TIME_W    = 48;
  localparam int VEL_W     = 48;
  localparam int DIFF_W    = POS_W + 1;
  localparam int MIL_W     = 20;
  localparam int PROD_W    = DIFF_W + MIL_W;
  localparam int DVD_W     = 52;
  localparam int DVS_W     = TIME_W;
  localparam int SIGN_W    = 2;

  localparam int HISTORY_DEPTH = 8;

  localparam logic [MIL_W-1:0] USEC_PER_SEC = MIL_W'(1000000);

  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'((64'd1 << (VEL_W - 1)) - 64'd1);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'd1 << (VEL_W - 1));
  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic        [TIME_W-1:0] sample_time;
  } in_req_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    reversal;
    logic                    time_error;
  } out_req_t;

  typedef struct packed {
    logic              valid;
    logic [SIGN_W-1:0] sign;
  } hist_upd_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

### rtl/core/vrd_div.sv
// vrd_div: shared restoring divider, one quotient bit per cycle.
// Depends on vrd_pkg.
module vrd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vrd_pkg::DVD_W-1:0]   dividend,
  input  logic [vrd_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [vrd_pkg::DVD_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(vrd_pkg::DVD_W);

  logic [vrd_pkg::DVS_W-1:0] rem_r;
  logic [vrd_pkg::DVD_W-1:0] quo_r;
  logic [vrd_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [vrd_pkg::DVS_W:0]   shifted;
  logic [vrd_pkg::DVS_W+1:0] trial;
  logic                      ge;

  assign shifted = {rem_r, quo_r[vrd_pkg::DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~trial[vrd_pkg::DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(vrd_pkg::DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[vrd_pkg::DVS_W-1:0] : shifted[vrd_pkg::DVS_W-1:0];
      quo_r <= {quo_r[vrd_pkg::DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/vrd_hist.sv
// vrd_hist: x-velocity sign shift store with running positive/negative counts.
// Depends on vrd_pkg.
module vrd_hist #(
  parameter int DEPTH = vrd_pkg::HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vrd_pkg::hist_upd_t upd,
  output logic               reversal
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [vrd_pkg::SIGN_W-1:0] hist_r [DEPTH];
  logic [CNT_W-1:0]           pos_cnt_r;
  logic [CNT_W-1:0]           neg_cnt_r;
  logic [CNT_W-1:0]           pos_cnt_nxt;
  logic [CNT_W-1:0]           neg_cnt_nxt;
  logic                       in_pos;
  logic                       in_neg;
  logic                       out_pos;
  logic                       out_neg;

  assign in_pos  = (upd.sign == vrd_pkg::SIGN_POS);
  assign in_neg  = (upd.sign == vrd_pkg::SIGN_NEG);
  assign out_pos = (hist_r[DEPTH-1] == vrd_pkg::SIGN_POS);
  assign out_neg = (hist_r[DEPTH-1] == vrd_pkg::SIGN_NEG);

  assign pos_cnt_nxt = pos_cnt_r + CNT_W'(in_pos) - CNT_W'(out_pos);
  assign neg_cnt_nxt = neg_cnt_r + CNT_W'(in_neg) - CNT_W'(out_neg);

  // result for the entry being shifted in this cycle
  assign reversal = (pos_cnt_nxt != '0) && (neg_cnt_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
      neg_cnt_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= vrd_pkg::SIGN_ZERO;
      end
    end else if (upd.valid) begin
      pos_cnt_r <= pos_cnt_nxt;
      neg_cnt_r <= neg_cnt_nxt;
      hist_r[0] <= upd.sign;
      for (int i = 1; i < DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

endmodule

### rtl/core/velocity_reversal_detector_unit.sv
// velocity_reversal_detector_unit: top level, sequencer around the shared divider.
// Depends on vrd_pkg, vrd_div, vrd_hist.
//
//  channel | ports                            | direction
//  --------+----------------------------------+----------
//  request | in_valid, in_ready, in_data      | in
//  result  | out_valid, out_ready, out_data   | out
//
// A request with a positive time step runs x and then y through a difference
// step, a multiply step and the shared restoring divider (one quotient bit
// per cycle over 52 dividend bits). A request with a time error goes straight
// to the finish state. Reset is synchronous and clears the previous sample and
// the sign store. The result register lets the next request in while a result
// waits on out_ready.
module velocity_reversal_detector_unit #(
  parameter int HISTORY_DEPTH = vrd_pkg::HISTORY_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vrd_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vrd_pkg::out_req_t out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  vrd_pkg::in_req_t             cur_r;
  logic [vrd_pkg::POS_W-1:0]    prev_x_r;
  logic [vrd_pkg::POS_W-1:0]    prev_y_r;
  logic [vrd_pkg::TIME_W-1:0]   prev_time_r;
  logic [vrd_pkg::TIME_W-1:0]   dt_r;
  logic                         terr_r;
  logic                         comp_r;
  logic [vrd_pkg::DIFF_W-1:0]   mag_r;
  logic                         neg_r;
  logic [vrd_pkg::VEL_W-1:0]    vx_r;
  logic [vrd_pkg::VEL_W-1:0]    vy_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  vrd_pkg::out_req_t            out_data_r;

  logic                         in_acc;
  logic                         fin_load;
  logic [vrd_pkg::POS_W-1:0]    sel_cur;
  logic [vrd_pkg::POS_W-1:0]    sel_prev;
  logic [vrd_pkg::DIFF_W-1:0]   diff;
  logic [vrd_pkg::PROD_W-1:0]   prod;
  logic [vrd_pkg::VEL_W-1:0]    vel_sat;
  logic [vrd_pkg::DVD_W-1:0]    div_quo;
  vrd_pkg::div_ctl_t            div_ctl;
  vrd_pkg::hist_upd_t           hist_upd;
  logic                         hist_rev;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign fin_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sel_cur  = comp_r ? cur_r.pos_y : cur_r.pos_x;
  assign sel_prev = comp_r ? prev_y_r : prev_x_r;
  assign diff     = {sel_cur[vrd_pkg::POS_W-1], sel_cur}
                  - {sel_prev[vrd_pkg::POS_W-1], sel_prev};
  assign prod     = vrd_pkg::PROD_W'(mag_r) * vrd_pkg::PROD_W'(vrd_pkg::USEC_PER_SEC);

  always_comb begin
    if (!neg_r) begin
      vel_sat = (div_quo > vrd_pkg::POS_LIM) ? vrd_pkg::VEL_MAX
                                             : div_quo[vrd_pkg::VEL_W-1:0];
    end else begin
      vel_sat = (div_quo > vrd_pkg::NEG_LIM) ? vrd_pkg::VEL_MIN
                                             : '0 - div_quo[vrd_pkg::VEL_W-1:0];
    end
  end

  assign div_ctl.start = (state_r == ST_MUL);

  vrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_ctl.start),
    .dividend (prod[vrd_pkg::DVD_W-1:0]),
    .divisor  (dt_r),
    .done     (div_ctl.done),
    .quotient (div_quo)
  );

  assign hist_upd.valid = fin_load;
  assign hist_upd.sign  = vx_r[vrd_pkg::VEL_W-1] ? vrd_pkg::SIGN_NEG :
                          (vx_r != '0)          ? vrd_pkg::SIGN_POS :
                                                  vrd_pkg::SIGN_ZERO;

  vrd_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (hist_upd),
    .reversal (hist_rev)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.sample_time <= prev_time_r) ? ST_FIN : ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_ctl.done) begin
          state_nxt = comp_r ? ST_FIN : ST_DIFF;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_time_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_load) begin
        prev_x_r    <= cur_r.pos_x;
        prev_y_r    <= cur_r.pos_y;
        prev_time_r <= cur_r.sample_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r  <= in_data;
      dt_r   <= in_data.sample_time - prev_time_r;
      terr_r <= (in_data.sample_time <= prev_time_r);
      comp_r <= 1'b0;
      vx_r   <= '0;
      vy_r   <= '0;
    end
    if (state_r == ST_DIFF) begin
      neg_r <= diff[vrd_pkg::DIFF_W-1];
      mag_r <= diff[vrd_pkg::DIFF_W-1] ? ('0 - diff) : diff;
    end
    if ((state_r == ST_DIV) && div_ctl.done) begin
      if (comp_r) begin
        vy_r <= vel_sat;
      end else begin
        vx_r <= vel_sat;
      end
      comp_r <= 1'b1;
    end
    if (fin_load) begin
      out_data_r.vel_x      <= vx_r;
      out_data_r.vel_y      <= vy_r;
      out_data_r.reversal   <= hist_rev;
      out_data_r.time_error <= terr_r;
    end
  end

endmodule

### rtl/core/vrd_checker.sv
// vrd_checker: port-level checks for velocity_reversal_detector_unit, with bind.
// Depends on vrd_pkg.
module vrd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input vrd_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input vrd_pkg::out_req_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // time error forces zero velocity
  a_terr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.time_error |-> (out_data.vel_x == '0) && (out_data.vel_y == '0))
    else $error("nonzero velocity on time error");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind velocity_reversal_detector_unit vrd_checker u_vrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/velocity_reversal_detector_unit_test.sv
// velocity_reversal_detector_unit_test: self-checking bench for the velocity reversal
// detector. Predicts velocities, time errors and reversal flags per request and
// compares them with the results. Depends on vrd_pkg and velocity_reversal_detector_unit.
module velocity_reversal_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 235;

  localparam logic signed [vrd_pkg::POS_W-1:0] POS_HI = {1'b0, {(vrd_pkg::POS_W-1){1'b1}}};
  localparam logic signed [vrd_pkg::POS_W-1:0] POS_LO = {1'b1, {(vrd_pkg::POS_W-1){1'b0}}};
  localparam logic [vrd_pkg::TIME_W-1:0]       TIME_HI = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  vrd_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  vrd_pkg::out_req_t out_data;

  velocity_reversal_detector_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  vrd_pkg::in_req_t  pending_samples[$];
  vrd_pkg::out_req_t expected_motion[$];
  int                mismatches = 0;

  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int unsigned hold_tok = 0;

  // predicted detector state
  logic signed [vrd_pkg::POS_W-1:0]  last_x = '0;
  logic signed [vrd_pkg::POS_W-1:0]  last_y = '0;
  logic        [vrd_pkg::TIME_W-1:0] last_time = '0;
  logic        [vrd_pkg::SIGN_W-1:0] sign_trail [vrd_pkg::HISTORY_DEPTH];

  initial begin
    for (int i = 0; i < vrd_pkg::HISTORY_DEPTH; i++) sign_trail[i] = vrd_pkg::SIGN_ZERO;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic logic signed [vrd_pkg::VEL_W-1:0] rate_of(
      logic signed [vrd_pkg::POS_W-1:0] now,
      logic signed [vrd_pkg::POS_W-1:0] was,
      longint span);
    longint delta;
    longint q;
    delta = longint'(now) - longint'(was);
    q = (delta * longint'(vrd_pkg::USEC_PER_SEC)) / span;
    if (q > longint'(vrd_pkg::VEL_MAX)) q = longint'(vrd_pkg::VEL_MAX);
    if (q < longint'($signed(vrd_pkg::VEL_MIN))) q = longint'($signed(vrd_pkg::VEL_MIN));
    return vrd_pkg::VEL_W'(q);
  endfunction

  function automatic void predict_motion(vrd_pkg::in_req_t s);
    vrd_pkg::out_req_t r;
    longint            span;
    bit                pos_seen;
    bit                neg_seen;
    span = longint'(s.sample_time) - longint'(last_time);
    r = '0;
    pos_seen = 1'b0;
    neg_seen = 1'b0;
    r.time_error = (span <= 0);
    if (!r.time_error) begin
      r.vel_x = rate_of(s.pos_x, last_x, span);
      r.vel_y = rate_of(s.pos_y, last_y, span);
    end
    for (int i = vrd_pkg::HISTORY_DEPTH - 1; i > 0; i--) sign_trail[i] = sign_trail[i-1];
    sign_trail[0] = (r.vel_x > 0) ? vrd_pkg::SIGN_POS :
                    ((r.vel_x < 0) ? vrd_pkg::SIGN_NEG : vrd_pkg::SIGN_ZERO);
    for (int i = 0; i < vrd_pkg::HISTORY_DEPTH; i++) begin
      if (sign_trail[i] == vrd_pkg::SIGN_POS) pos_seen = 1'b1;
      else if (sign_trail[i] == vrd_pkg::SIGN_NEG) neg_seen = 1'b1;
    end
    r.reversal = pos_seen && neg_seen;
    last_x = s.pos_x;
    last_y = s.pos_y;
    last_time = s.sample_time;
    expected_motion.push_back(r);
  endfunction

  task automatic check_motion(vrd_pkg::out_req_t got);
    vrd_pkg::out_req_t want;
    if (expected_motion.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = expected_motion.pop_front();
    if (got.vel_x !== want.vel_x)
      report_mismatch($sformatf("vel_x got %0d want %0d", got.vel_x, want.vel_x));
    if (got.vel_y !== want.vel_y)
      report_mismatch($sformatf("vel_y got %0d want %0d", got.vel_y, want.vel_y));
    if (got.reversal !== want.reversal)
      report_mismatch($sformatf("reversal got %b want %b", got.reversal, want.reversal));
    if (got.time_error !== want.time_error)
      report_mismatch($sformatf("time_error got %b want %b", got.time_error, want.time_error));
  endtask

  // request driver
  int unsigned gap_left = 0;

  always @(posedge clk) begin : driver
    bit          busy;
    int unsigned g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      g = gap_left;
      if (in_valid && in_ready) begin
        predict_motion(in_data);
        g = tx_idle ? $urandom_range(0, 15) : 0;
      end
      busy = in_valid && !in_ready;
      if (!busy) begin
        if (g > 0) begin
          in_valid <= 1'b0;
          g = g - 1;
        end else if (pending_samples.size() != 0) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      gap_left <= g;
    end
  end

  // result monitor
  int unsigned wait_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk) begin : monitor
    bit          rdy;
    int unsigned w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      wait_left <= 0;
      hold_left <= 0;
    end else begin
      rdy = 1'b1;
      w = wait_left;
      if (out_valid && out_ready) begin
        check_motion(out_data);
        w = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold_tok != hold_seen) begin
        hold_seen <= hold_tok;
        hold_left <= HOLD_CYCLES;
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (w > 0) begin
        w = w - 1;
        rdy = 1'b0;
      end
      wait_left <= w;
      out_ready <= rdy;
    end
  end

  // watchdog
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("velocity_reversal_detector_unit_test: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  logic signed [vrd_pkg::POS_W-1:0]  gen_x = '0;
  logic signed [vrd_pkg::POS_W-1:0]  gen_y = '0;
  logic        [vrd_pkg::TIME_W-1:0] gen_time = '0;

  task automatic add_sample(logic signed [vrd_pkg::POS_W-1:0] x,
                            logic signed [vrd_pkg::POS_W-1:0] y,
                            logic [vrd_pkg::TIME_W-1:0] t);
    vrd_pkg::in_req_t s;
    s.pos_x = x;
    s.pos_y = y;
    s.sample_time = t;
    pending_samples.push_back(s);
    gen_x = x;
    gen_y = y;
    gen_time = t;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_motion.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int unsigned kind;
    int          run_dir;
    int          run_left;
    int          step;
    int          dy;
    bit          slow;
    logic signed [vrd_pkg::POS_W-1:0]  nx;
    logic signed [vrd_pkg::POS_W-1:0]  ny;
    logic        [vrd_pkg::TIME_W-1:0] nt;

    run_dir = 0;
    run_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    add_sample(0, 0, 0);                      // first sample, zero step
    add_sample(POS_HI, POS_LO, 1);            // saturate high x, low y
    add_sample(POS_LO, POS_HI, 2);            // saturate low x, high y; reversal
    add_sample(POS_LO, POS_HI, 2);            // zero step
    add_sample(12345, -777, 1);               // step backwards
    add_sample(0, 0, TIME_HI);                // step to the largest time
    add_sample(-1, 1, 0);                     // step back over the full range
    add_sample(0, 0, 1000001);                // truncates to zero
    add_sample(1, -1, 2000001);               // exactly one unit per second
    for (int i = 0; i < vrd_pkg::HISTORY_DEPTH + 1; i++)
      add_sample(1, -1, gen_time + 1000);     // flush signs with zero velocity
    add_sample(5, 5, gen_time + 10);
    add_sample(2, 2, gen_time + 10);
    wait_drained();

    // random phases, sender pauses until drained after each
    for (int p = 0; p < PHASES; p++) begin
      tx_idle = (p % 2 == 1) || (p >= 5);
      rx_idle = (p % 4 >= 2) || (p >= 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        nx = gen_x;
        ny = gen_y;
        if (kind < 60) begin
          if (run_left == 0) begin
            run_dir = $urandom_range(0, 2);
            run_left = $urandom_range(1, 20);
          end
          run_left--;
          slow = ($urandom_range(0, 9) == 0);
          step = slow ? int'($urandom_range(0, 1)) : int'($urandom_range(0, 4000));
          dy = int'($urandom_range(0, 8000)) - 4000;
          nx = gen_x + ((run_dir == 0) ? 0 : ((run_dir == 1) ? step : -step));
          ny = gen_y + dy;
          nt = gen_time + (slow ? $urandom_range(1000001, 4000000) : $urandom_range(1, 20000));
        end else if (kind < 75) begin
          nx = $urandom;
          ny = $urandom;
          nt = gen_time + $urandom_range(1, 3);
        end else if (kind < 85) begin
          nx = $urandom;
          ny = $urandom;
          nt = gen_time + $urandom;
        end else if (kind < 93) begin
          nx = gen_x + $urandom_range(0, 100);
          nt = gen_time - $urandom_range(0, 50000);
        end else begin
          nx = $urandom;
          ny = $urandom;
          nt = vrd_pkg::TIME_W'({$urandom, $urandom});
        end
        add_sample(nx, ny, nt);
      end
      if (p == 4) hold_tok = hold_tok + 1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_motion.size() != 0) report_mismatch("results still outstanding at end");
    if (mismatches == 0) begin
      $display("velocity_reversal_detector_unit_test: PASS");
    end else begin
      $display("velocity_reversal_detector_unit_test: FAIL");
    end
    $finish;
  end

endmodule
